[hdl/mvts_pkg.sv]
// ---------------------------------------------------------------------------
// mvts_pkg
// Shared types, codes and constants of the multi-voice tone and noise synth.
// ---------------------------------------------------------------------------
`default_nettype none

package mvts_pkg;

  // Default voice count of the top level.
  localparam int CHANNELS_DEF = 32;

  // Normalization constants.
  localparam int VOL_ONE_SQ = 65025;
  localparam int SCALE_ONE  = 32768;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SAMPLE_RATE     = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_MASTER_VOLUME   = 2'd2;

  // Wave types.
  localparam logic [3:0] WT_PULSE_HALF = 4'd0;
  localparam logic [3:0] WT_PULSE_1831 = 4'd1;
  localparam logic [3:0] WT_PULSE_8TH  = 4'd2;
  localparam logic [3:0] WT_POLY4      = 4'd3;
  localparam logic [3:0] WT_POLY5      = 4'd4;
  localparam logic [3:0] WT_POLY9      = 4'd5;
  localparam logic [3:0] WT_POLY4_G5   = 4'd6;
  localparam logic [3:0] WT_POLY17     = 4'd7;
  localparam logic [3:0] WT_POLY17_G9  = 4'd8;

  // Settings of one voice as stored in the setting memories.
  typedef struct packed {
    logic [3:0]  wtype;
    logic [23:0] freq;
    logic [7:0]  vol;
    logic [7:0]  pan;
  } voice_cfg_t;

  // Running state of one voice.
  typedef struct packed {
    logic [25:0] phase;
    logic        outb;
    logic [3:0]  sr4;
    logic [4:0]  sr5;
    logic [8:0]  sr9;
    logic [16:0] sr17;
  } voice_st_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CP_RD,
    S_CP_WR,
    S_CP_DIV,
    S_CP_WAIT,
    S_TK_RD,
    S_TK_MUL,
    S_TK_ADD,
    S_TK_CMP,
    S_TK_MOD,
    S_TK_WR,
    S_MX_MUL,
    S_MX_DIV,
    S_MX_WAIT,
    S_MX_OUT
  } state_t;

  // Per-type tuning factor in Q16.
  function automatic logic [18:0] tune_q16(input logic [3:0] t);
    logic [18:0] r;
    case (t)
      WT_POLY4, WT_POLY4_G5: r = 19'd247431;
      WT_POLY5, WT_POLY9, WT_POLY17, WT_POLY17_G9: r = 19'd262144;
      default: r = 19'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/mvts_ram.sv]
// ---------------------------------------------------------------------------
// mvts_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module mvts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/mvts_div.sv]
// ---------------------------------------------------------------------------
// mvts_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mvts_div
  import mvts_pkg::*;
#(
  parameter int DW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [25:0]   divisor,
  output logic      [DW-1:0] quot,
  output logic      [25:0]   rem,
  output div_stat_t          stat
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_r;
  logic [25:0]     rem_r;
  logic [25:0]     dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [26:0]     trial;
  logic            fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? 26'(trial - {1'b0, dvs_r}) : trial[25:0];
    end
  end

  assign quot      = quo_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[hdl/multi_voice_tone_noise_synth.sv]
// ---------------------------------------------------------------------------
// multi_voice_tone_noise_synth
// Multi-voice pulse and polynomial-counter noise synth with stereo mixing.
// ---------------------------------------------------------------------------
//
//  Channel  Ports                                  Moves
//  -------  -------------------------------------  ---------------------------
//  in       in_valid/in_ready, in_* fields         write, commit or tick request
//  out      out_valid/out_ready, out_* fields      one stereo sample per tick
//  cfg      cfg_we, cfg_index, cfg_data            register write, no wait
//
// A write request is stored straight from idle. A commit runs a copy sweep
// over all CHANNELS voices and then one division in the shared divider. A
// tick steps through the active voices, an enabled voice also using the divider
// when its phase wraps (the divider forms the remainder), and then runs the mix,
// which uses the divider twice.
// The voice state memory has valid bits cleared by reset, so no clearing
// pass is needed. A new request is taken while a finished sample waits;
// a tick stalls at its end only while the previous sample is still held.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_voice_tone_noise_synth
  import mvts_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_kind,
  input  wire logic [4:0]        in_voice_index,
  input  wire logic [3:0]        in_wave_type,
  input  wire logic [23:0]       in_frequency,
  input  wire logic [7:0]        in_volume,
  input  wire logic signed [7:0] in_pan,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_left_sample,
  output logic [7:0]             out_right_sample,
  output logic [5:0]             out_active_voices,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [17:0]       cfg_data
);

  localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW   = $clog2(CHANNELS + 1);
  localparam int SUMW = 16 + CW;
  localparam int ACCW = 23 + CW;
  localparam int XW   = ACCW + 16;
  localparam int DW   = (ACCW + 1 > 31) ? ACCW + 1 : 31;
  localparam int CFGW = $bits(voice_cfg_t);
  localparam int STW  = $bits(voice_st_t);

  // Configuration registers.
  logic [17:0] sample_rate_r;
  logic [5:0]  act_ch_r;
  logic [7:0]  master_vol_r;

  // Sequencer and datapath registers.
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r;
  logic [SUMW-1:0] sum_r;
  logic [15:0]     ms_r;
  logic            act_init_r;
  logic            pend_vld_r [CHANNELS];
  logic            st_vld_r   [CHANNELS];
  voice_cfg_t      cfg_r;
  voice_st_t       st_r;
  logic [25:0]     inc_r;
  logic [15:0]     vol2_r;
  logic [26:0]     ph_r;
  logic [ACCW-1:0] accl_r, accr_r;
  logic [5:0]      vcnt_r;
  logic            side_r;
  logic [XW-1:0]   x_r;
  logic [7:0]      ql_r, qr_r;
  logic            out_valid_r;
  logic [7:0]      out_l_r, out_r_r;
  logic [5:0]      out_n_r;

  // Memory and divider connections.
  logic              pend_we;
  logic [AW-1:0]     pend_waddr;
  logic [CFGW-1:0]   pend_rdata;
  logic              act_we;
  logic [CFGW-1:0]   act_wdata, act_rdata;
  logic              st_we;
  logic [STW-1:0]    st_wdata, st_rdata;
  logic [AW-1:0]     addr;
  logic              div_start;
  logic [DW-1:0]     div_dividend;
  logic [25:0]       div_divisor;
  logic [DW-1:0]     div_quot;
  logic [25:0]       div_rem;
  div_stat_t         div_stat;

  // Combinational helpers.
  logic [5+AW-1:0]   idx_ext;
  logic              accept;
  logic [6:0]        nlim;
  logic              in_range;
  logic [25:0]       limit;
  voice_cfg_t        pcfg, acfg;
  voice_st_t         cur_st, wrap_st;
  logic [15:0]       cp_vol2, cur_vol2, mvsq;
  logic [41:0]       inc_prod;
  logic              cur_en, last_voice, wrap;
  logic [3:0]        s4n;
  logic [4:0]        s5n;
  logic [8:0]        s9n;
  logic [16:0]       s17n;
  logic [31:0]       p32, l32;
  logic              duty_off;
  logic signed [9:0] pan_s, gl_s, gr_s;
  logic [7:0]        gain_l, gain_r;
  logic [23:0]       pl, pr;
  logic [XW-1:0]     mx;
  logic [XW+6:0]     x127;
  logic [7:0]        qsat;

  // Memories: pending settings, active settings, voice state.
  mvts_ram #(.WIDTH(CFGW), .DEPTH(CHANNELS)) u_pend (
    .clk(clk), .we(pend_we), .waddr(pend_waddr),
    .wdata({in_wave_type, in_frequency, in_volume, in_pan}),
    .raddr(addr), .rdata(pend_rdata)
  );

  mvts_ram #(.WIDTH(CFGW), .DEPTH(CHANNELS)) u_act (
    .clk(clk), .we(act_we), .waddr(addr), .wdata(act_wdata),
    .raddr(addr), .rdata(act_rdata)
  );

  mvts_ram #(.WIDTH(STW), .DEPTH(CHANNELS)) u_st (
    .clk(clk), .we(st_we), .waddr(addr), .wdata(st_wdata),
    .raddr(addr), .rdata(st_rdata)
  );

  // Shared divider.
  mvts_div #(.DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quot(div_quot), .rem(div_rem), .stat(div_stat)
  );

  // Address, limits and the voice read back from the memories.
  always_comb begin
    idx_ext    = {AW'(0), in_voice_index};
    pend_waddr = idx_ext[AW-1:0];
    addr       = cnt_r[AW-1:0];
    accept     = in_valid && in_ready;
    nlim       = ({1'b0, act_ch_r} < 7'(CHANNELS)) ? {1'b0, act_ch_r} : 7'(CHANNELS);
    in_range   = (7'(cnt_r) < nlim);
    last_voice = (cnt_r == CW'(CHANNELS - 1));
    limit      = {((sample_rate_r == 18'd0) ? 18'd1 : sample_rate_r), 8'h00};
    pcfg       = pend_vld_r[addr] ? voice_cfg_t'(pend_rdata) : voice_cfg_t'('0);
    acfg       = act_init_r ? voice_cfg_t'(act_rdata) : voice_cfg_t'('0);
    if (st_vld_r[addr]) begin
      cur_st = voice_st_t'(st_rdata);
    end else begin
      cur_st       = '0;
      cur_st.sr4   = '1;
      cur_st.sr5   = '1;
      cur_st.sr9   = '1;
      cur_st.sr17  = '1;
    end
    cp_vol2  = pcfg.vol * pcfg.vol;
    cur_vol2 = acfg.vol * acfg.vol;
    mvsq     = master_vol_r * master_vol_r;
    inc_prod = acfg.freq * tune_q16(acfg.wtype) + 42'd32768;
    cur_en   = (acfg.freq != 24'd0) && (acfg.vol != 8'd0);
    wrap     = (ph_r >= {1'b0, limit});
  end

  // Shift register steps and the signal after a phase wrap.
  always_comb begin
    s4n     = {st_r.sr4[2:0], st_r.sr4[2] ^ st_r.sr4[3]};
    s5n     = {st_r.sr5[3:0], st_r.sr5[2] ^ st_r.sr5[4]};
    s9n     = {st_r.sr9[0] ^ st_r.sr9[5], st_r.sr9[8:1]};
    s17n    = {st_r.sr17[0] ^ st_r.sr17[5], st_r.sr17[16:1]};
    wrap_st = st_r;
    case (cfg_r.wtype)
      WT_PULSE_HALF, WT_PULSE_1831, WT_PULSE_8TH: begin
        wrap_st.outb = 1'b1;
      end
      WT_POLY4: begin
        wrap_st.sr4  = s4n;
        wrap_st.outb = s4n[0];
      end
      WT_POLY5: begin
        wrap_st.sr5  = s5n;
        wrap_st.outb = s5n[0];
      end
      WT_POLY9: begin
        wrap_st.sr9  = s9n;
        wrap_st.outb = s9n[0];
      end
      WT_POLY4_G5: begin
        wrap_st.sr5 = s5n;
        if (s5n[0]) begin
          wrap_st.sr4  = s4n;
          wrap_st.outb = s4n[0];
        end
      end
      WT_POLY17: begin
        wrap_st.sr17 = s17n;
        wrap_st.outb = s17n[0];
      end
      WT_POLY17_G9: begin
        wrap_st.sr9 = s9n;
        if (s9n[0]) begin
          wrap_st.sr17 = s17n;
          wrap_st.outb = s17n[0];
        end
      end
      default: begin
        wrap_st = st_r;
      end
    endcase
  end

  // Pulse duty check when the phase does not wrap.
  always_comb begin
    p32 = 32'(ph_r);
    l32 = 32'(limit);
    case (cfg_r.wtype)
      WT_PULSE_HALF: duty_off = ((p32 << 1) >= l32);
      WT_PULSE_1831: duty_off = (((p32 << 5) - p32) >= ((l32 << 4) + (l32 << 1)));
      WT_PULSE_8TH:  duty_off = ((p32 << 3) >= l32);
      default:       duty_off = 1'b0;
    endcase
  end

  // Pan gains, panned levels and the mix product.
  always_comb begin
    pan_s  = signed'({{2{cfg_r.pan[7]}}, cfg_r.pan});
    gl_s   = 10'sd128 - pan_s;
    gr_s   = 10'sd128 + pan_s;
    gain_l = (gl_s > 10'sd128) ? 8'd128 : gl_s[7:0];
    gain_r = (gr_s > 10'sd128) ? 8'd128 : gr_s[7:0];
    pl     = gain_l * vol2_r;
    pr     = gain_r * vol2_r;
    mx     = (side_r ? accr_r : accl_r) * ms_r;
    x127   = {x_r, 7'd0} - (XW+7)'(x_r);
    qsat   = (div_quot > DW'(127)) ? 8'd255 : {1'b1, div_quot[6:0]};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_COMMIT) begin
            state_nxt = S_CP_RD;
          end else if (in_kind == KIND_TICK) begin
            state_nxt = S_TK_RD;
          end
        end
      end
      S_CP_RD:   state_nxt = S_CP_WR;
      S_CP_WR:   state_nxt = last_voice ? S_CP_DIV : S_CP_RD;
      S_CP_DIV:  state_nxt = S_CP_WAIT;
      S_CP_WAIT: state_nxt = div_stat.done ? S_IDLE : S_CP_WAIT;
      S_TK_RD:   state_nxt = in_range ? S_TK_MUL : S_MX_MUL;
      S_TK_MUL:  state_nxt = cur_en ? S_TK_ADD : S_TK_RD;
      S_TK_ADD:  state_nxt = S_TK_CMP;
      S_TK_CMP:  state_nxt = wrap ? S_TK_MOD : S_TK_WR;
      S_TK_MOD:  state_nxt = div_stat.done ? S_TK_WR : S_TK_MOD;
      S_TK_WR:   state_nxt = S_TK_RD;
      S_MX_MUL:  state_nxt = S_MX_DIV;
      S_MX_DIV:  state_nxt = S_MX_WAIT;
      S_MX_WAIT: begin
        if (div_stat.done) begin
          state_nxt = side_r ? S_MX_OUT : S_MX_MUL;
        end
      end
      S_MX_OUT:  state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_MX_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control outputs: ready, memory writes and divider requests.
  always_comb begin
    in_ready     = (state_r == S_IDLE) && !div_stat.busy;
    pend_we      = 1'b0;
    act_we       = 1'b0;
    st_we        = 1'b0;
    div_start    = 1'b0;
    div_dividend = DW'(ph_r);
    div_divisor  = limit;
    act_wdata    = pcfg;
    st_wdata     = {ph_r[25:0], st_r.outb, st_r.sr4, st_r.sr5, st_r.sr9, st_r.sr17};
    case (state_r)
      S_IDLE: begin
        pend_we = accept && (in_kind == KIND_WRITE) && (idx_ext < (5+AW)'(CHANNELS));
      end
      S_CP_WR: begin
        act_we = 1'b1;
      end
      S_CP_DIV: begin
        div_start    = 1'b1;
        div_dividend = DW'({mvsq, 15'd0});
        div_divisor  = (sum_r > SUMW'(VOL_ONE_SQ)) ? 26'(sum_r) : 26'(VOL_ONE_SQ);
      end
      S_TK_CMP: begin
        div_start = wrap;
      end
      S_TK_WR: begin
        st_we = 1'b1;
      end
      S_MX_DIV: begin
        div_start    = 1'b1;
        div_dividend = DW'(x127[XW+6:22]);
        div_divisor  = 26'(VOL_ONE_SQ);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= 18'd44100;
      act_ch_r      <= 6'd32;
      master_vol_r  <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_RATE:     sample_rate_r <= cfg_data;
        CFG_ACTIVE_CHANNELS: act_ch_r      <= cfg_data[5:0];
        CFG_MASTER_VOLUME:   master_vol_r  <= cfg_data[7:0];
        default:             sample_rate_r <= sample_rate_r;
      endcase
    end
  end

  // Sequencer control state and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      act_init_r  <= 1'b0;
      ms_r        <= 16'(SCALE_ONE);
      out_valid_r <= 1'b0;
      side_r      <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pend_vld_r[i] <= 1'b0;
        st_vld_r[i]   <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r  <= '0;
          side_r <= 1'b0;
          if (pend_we) begin
            pend_vld_r[pend_waddr] <= 1'b1;
          end
        end
        S_CP_WR: begin
          cnt_r <= cnt_r + 1'b1;
        end
        S_CP_WAIT: begin
          if (div_stat.done) begin
            ms_r       <= div_quot[15:0];
            act_init_r <= 1'b1;
          end
        end
        S_TK_MUL: begin
          if (!cur_en) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_TK_WR: begin
          st_vld_r[addr] <= 1'b1;
          cnt_r          <= cnt_r + 1'b1;
        end
        S_MX_WAIT: begin
          if (div_stat.done) begin
            side_r <= 1'b1;
          end
        end
        S_MX_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        sum_r  <= '0;
        accl_r <= '0;
        accr_r <= '0;
        vcnt_r <= '0;
      end
      S_CP_WR: begin
        if (in_range && (pcfg.freq != 24'd0) && (pcfg.vol != 8'd0)) begin
          sum_r <= sum_r + SUMW'(cp_vol2);
        end
      end
      S_TK_MUL: begin
        cfg_r  <= acfg;
        st_r   <= cur_st;
        inc_r  <= inc_prod[41:16];
        vol2_r <= cur_vol2;
        if (cur_en) begin
          vcnt_r <= vcnt_r + 1'b1;
        end
      end
      S_TK_ADD: begin
        ph_r <= 27'(st_r.phase) + 27'(inc_r);
      end
      S_TK_CMP: begin
        if (!wrap && (cfg_r.wtype < WT_POLY4) && st_r.outb && duty_off) begin
          st_r.outb <= 1'b0;
        end
      end
      S_TK_MOD: begin
        if (div_stat.done) begin
          ph_r <= 27'(div_rem);
          st_r <= wrap_st;
        end
      end
      S_TK_WR: begin
        if (st_r.outb) begin
          accl_r <= accl_r + ACCW'(pl);
          accr_r <= accr_r + ACCW'(pr);
        end
      end
      S_MX_MUL: begin
        x_r <= mx;
      end
      S_MX_WAIT: begin
        if (div_stat.done) begin
          if (side_r) begin
            qr_r <= qsat;
          end else begin
            ql_r <= qsat;
          end
        end
      end
      S_MX_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_l_r <= ql_r;
          out_r_r <= qr_r;
          out_n_r <= vcnt_r;
        end
      end
      default: begin
        x_r <= x_r;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_left_sample   = out_l_r;
  assign out_right_sample  = out_r_r;
  assign out_active_voices = out_n_r;

endmodule

`default_nettype wire
